// File: rtl/ihs_pkg.sv
// ============================================================================
// Image header size sniffer: shared package
// Types, sizes, format codes and signature bytes used by the sniffer modules.
// ============================================================================
package ihs_pkg;

    // Number of leading file bytes that are kept for the signature checks.
    localparam int HDR_LEN      = 24;
    localparam int HDR_IDX_BITS = $clog2(HDR_LEN);
    // Length of the sliding marker segment window.
    localparam int WIN_LEN      = 12;
    // Bytes kept from a committed window: 0, 1, 5, 6, 7 and 8.
    localparam int COM_LEN      = 6;

    // Result format codes.
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_JPEG = 2'd1;
    localparam logic [1:0] FMT_GIF  = 2'd2;
    localparam logic [1:0] FMT_PNG  = 2'd3;

    // JPEG markers.
    localparam logic [7:0] JPG_LEAD = 8'hFF;
    localparam logic [7:0] JPG_SOI  = 8'hD8;
    localparam logic [7:0] JPG_APP0 = 8'hE0;

    // ASCII letters used by the signatures.
    localparam logic [7:0] CH_J = 8'h4A;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_R = 8'h52;

    // PNG magic bytes other than the letters.
    localparam logic [7:0] PNG_HIGH = 8'h89;
    localparam logic [7:0] PNG_CR   = 8'h0D;
    localparam logic [7:0] PNG_LF   = 8'h0A;
    localparam logic [7:0] PNG_EOF  = 8'h1A;

    typedef logic [HDR_LEN-1:0][7:0] hdr_t;
    typedef logic [WIN_LEN-1:0][7:0] win_t;
    typedef logic [COM_LEN-1:0][7:0] com_t;

    // Everything the result stage needs about one finished file.
    typedef struct packed {
        hdr_t hdr;
        com_t com;
        logic long_file;
    } snap_t;

    // Start-of-frame markers end the segment walk.
    function automatic logic is_sof(input logic [7:0] m);
        return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC9 && m <= 8'hCB);
    endfunction

endpackage

// File: rtl/ihs_if.sv
// ============================================================================
// Image header size sniffer: channel interfaces
// Byte input channel and dimension result channel, valid/ready handshake.
// ============================================================================
interface ihs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihs_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [1:0]  image_format;
    logic [31:0] width;
    logic [31:0] height;

    modport source (output valid, output found, output image_format, output width,
                    output height, input ready);
    modport sink   (input valid, input found, input image_format, input width,
                    input height, output ready);
endinterface

// File: rtl/image_header_size_sniffer.sv
// ============================================================================
// Image header size sniffer: top level
// Reads an image file byte by byte and reports JPEG, GIF or PNG dimensions.
// ============================================================================
//
//   Channel   Role     Item                          Accepted when
//   stream    sink     data_byte, last_byte          valid && ready
//   report    source   found, image_format,          valid && ready
//                      width, height
//
// One byte item is taken every clock cycle while the queue is not full; the
// front end does all per-byte work (header store, window shift, segment
// commit) as the byte is taken. A file's snapshot enters the queue with its
// last byte and the output register once that is empty or being read.
// The stream side stalls only while the queue is full, i.e. when three results
// wait behind a stalled report side, two in the queue and one in the output
// register.
// Reset (rst_n low, asynchronous) empties the queue and output and readies
// the front end for the first byte of a new file; no clearing pass is needed.
// ============================================================================
module image_header_size_sniffer #(
    parameter int POSITION_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ihs_byte_if.sink     stream,
    ihs_result_if.source report
);
    import ihs_pkg::*;

    // Handshake between the front end and the queue.
    logic  push;
    snap_t push_data;
    logic  queue_full;

    // Handshake between the queue and the result stage.
    logic  pop;
    logic  queue_empty;
    snap_t pop_data;

    // The front end tracks the file and, on its last byte, pushes a snapshot
    // of the header bytes and the last committed JPEG segment.
    ihs_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // The queue lets the byte side run on while results wait to be taken.
    ihs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .empty     (queue_empty),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    // The result stage picks the format in JPEG, GIF, PNG order and holds
    // the dimensions in its output register.
    ihs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (queue_empty),
        .pop_data (pop_data),
        .pop      (pop),
        .report   (report)
    );

endmodule

// File: rtl/ihs_front.sv
// ============================================================================
// Image header size sniffer: front end
// Takes file bytes, keeps the header, walks JPEG segments and hands a
// snapshot of the file to the queue when the last byte arrives.
// ============================================================================
module ihs_front #(
    parameter int POSITION_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    ihs_byte_if.sink      stream,
    input  logic          queue_full,
    output logic          push,
    output ihs_pkg::snap_t push_data
);
    import ihs_pkg::*;

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] POS_MAX = '1;
    localparam logic [P-1:0] SEG_FIRST = P'(2);

    logic [P-1:0] pos_reg, pos_next;
    logic [P-1:0] seg_reg, seg_next;
    logic         walk_reg, walk_next;
    win_t         win_reg, win_shift;
    hdr_t         hdr_reg, hdr_next;
    com_t         com_reg, com_next;

    logic         accept;
    logic         tracked;
    logic         hit;
    logic         jfif;
    logic         stop;
    logic [P:0]   seg_end;
    logic [P+1:0] seg_sum;
    logic [P-1:0] seg_sat;

    assign stream.ready = !queue_full;
    assign accept       = stream.valid && !queue_full;

    assign win_shift = {stream.data_byte, win_reg[WIN_LEN-1:1]};
    assign tracked   = (pos_reg != POS_MAX);
    assign seg_end   = {1'b0, seg_reg} + (P+1)'(WIN_LEN - 1);
    assign hit       = tracked && walk_reg && ({1'b0, pos_reg} == seg_end);

    assign jfif = hdr_reg[0] == JPG_LEAD && hdr_reg[1] == JPG_SOI &&
                  hdr_reg[2] == JPG_LEAD && hdr_reg[3] == JPG_APP0 &&
                  hdr_reg[6] == CH_J && hdr_reg[7] == CH_F &&
                  hdr_reg[8] == CH_I && hdr_reg[9] == CH_F;

    assign stop = ((seg_reg == SEG_FIRST) && !jfif) ||
                  (win_shift[0] != JPG_LEAD) || is_sof(win_shift[1]);

    // Next segment start: current start plus marker plus the length field.
    assign seg_sum = {2'b00, seg_reg} + (P+2)'(2) +
                     (P+2)'({win_shift[2], win_shift[3]});
    assign seg_sat = (|seg_sum[P+1:P]) ? POS_MAX : seg_sum[P-1:0];

    always_comb
    begin
        hdr_next  = hdr_reg;
        com_next  = com_reg;
        seg_next  = seg_reg;
        walk_next = walk_reg;
        pos_next  = pos_reg;
        if (tracked)
        begin
            if (pos_reg < P'(HDR_LEN))
            begin
                hdr_next[pos_reg[HDR_IDX_BITS-1:0]] = stream.data_byte;
            end
            if (hit)
            begin
                com_next = {win_shift[8], win_shift[7], win_shift[6],
                            win_shift[5], win_shift[1], win_shift[0]};
                if (stop)
                begin
                    walk_next = 1'b0;
                end
                else
                begin
                    seg_next = seg_sat;
                end
            end
            pos_next = pos_reg + P'(1);
        end
    end

    assign push                = accept && stream.last_byte;
    assign push_data.hdr       = hdr_next;
    assign push_data.com       = com_next;
    assign push_data.long_file = (pos_next >= P'(HDR_LEN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            seg_reg  <= SEG_FIRST;
            walk_reg <= 1'b1;
            com_reg  <= '0;
        end
        else if (accept)
        begin
            if (stream.last_byte)
            begin
                // The file is done: start over for the next one.
                pos_reg  <= '0;
                seg_reg  <= SEG_FIRST;
                walk_reg <= 1'b1;
                com_reg  <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                seg_reg  <= seg_next;
                walk_reg <= walk_next;
                com_reg  <= com_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_shift;
            hdr_reg <= hdr_next;
        end
    end

endmodule

// File: rtl/ihs_queue.sv
// ============================================================================
// Image header size sniffer: snapshot queue
// Two-entry queue between the front end and the result stage.
// ============================================================================
module ihs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ihs_pkg::snap_t push_data,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output ihs_pkg::snap_t pop_data
);
    import ihs_pkg::*;

    snap_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/ihs_back.sv
// ============================================================================
// Image header size sniffer: result stage
// Decides the format of a finished file and registers its dimensions.
// ============================================================================
module ihs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  ihs_pkg::snap_t pop_data,
    output logic           pop,
    ihs_result_if.source   report
);
    import ihs_pkg::*;

    logic        out_valid_reg;
    logic        found_reg;
    logic [1:0]  format_reg;
    logic [31:0] width_reg;
    logic [31:0] height_reg;

    logic        is_jpeg;
    logic        is_gif;
    logic        is_png;
    logic [1:0]  fmt;
    logic [31:0] w;
    logic [31:0] h;
    hdr_t        hb;
    com_t        cb;

    assign hb = pop_data.hdr;
    assign cb = pop_data.com;

    assign is_jpeg = hb[0] == JPG_LEAD && hb[1] == JPG_SOI && cb[0] == JPG_LEAD;
    assign is_gif  = hb[0] == CH_G && hb[1] == CH_I && hb[2] == CH_F;
    assign is_png  = hb[0] == PNG_HIGH && hb[1] == CH_P && hb[2] == CH_N &&
                     hb[3] == CH_G && hb[4] == PNG_CR && hb[5] == PNG_LF &&
                     hb[6] == PNG_EOF && hb[7] == PNG_LF &&
                     hb[12] == CH_I && hb[13] == CH_H &&
                     hb[14] == CH_D && hb[15] == CH_R;

    always_comb
    begin
        fmt = FMT_NONE;
        w   = '0;
        h   = '0;
        if (pop_data.long_file)
        begin
            if (is_jpeg)
            begin
                fmt = FMT_JPEG;
                h   = {16'h0000, cb[2], cb[3]};
                w   = {16'h0000, cb[4], cb[5]};
            end
            else if (is_gif)
            begin
                fmt = FMT_GIF;
                w   = {16'h0000, hb[7], hb[6]};
                h   = {16'h0000, hb[9], hb[8]};
            end
            else if (is_png)
            begin
                fmt = FMT_PNG;
                w   = {hb[16], hb[17], hb[18], hb[19]};
                h   = {hb[20], hb[21], hb[22], hb[23]};
            end
        end
    end

    assign pop = !empty && (!out_valid_reg || report.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg  <= (fmt != FMT_NONE);
            format_reg <= fmt;
            width_reg  <= w;
            height_reg <= h;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.found        = found_reg;
    assign report.image_format = format_reg;
    assign report.width        = width_reg;
    assign report.height       = height_reg;

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Image header size sniffer: testbench
// Streams whole image files into the sniffer and checks each reported format,
// width and height against a byte-level tracker of the header parser.
// ============================================================================
module tb;
    import ihs_pkg::*;

    // ------------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------------
    localparam int              POS_BITS   = 32;
    localparam longint unsigned POS_LIMIT  = (64'd1 << POS_BITS) - 1;
    localparam int              IDLE_LIMIT = 3000;
    localparam int              SHOWN_MAX  = 10;

    // SOF markers are 0xC0..0xC3 and 0xC9..0xCB.
    localparam logic [3:0] SOF_NIBBLE  = 4'hC;
    localparam logic [7:0] SOF_BASE    = 8'hC0;
    // Flipping this bit of a SOF code always gives a code that is not SOF.
    localparam logic [7:0] NOT_SOF_BIT = 8'h04;

    // One reported item on the result channel.
    typedef struct packed {
        logic        found;
        logic [1:0]  fmt;
        logic [31:0] width;
        logic [31:0] height;
    } size_report_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    ihs_byte_if   stream_if();
    ihs_result_if report_if();

    image_header_size_sniffer #(.POSITION_BITS(POS_BITS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .report (report_if)
    );

    // ------------------------------------------------------------------------
    // Tracker state: a byte-accurate copy of what the parser keeps per file.
    // ------------------------------------------------------------------------
    logic [7:0]      hdr_copy [HDR_LEN];
    logic [7:0]      win_copy [WIN_LEN];
    logic [7:0]      seg_copy [COM_LEN];
    longint unsigned byte_count;
    longint unsigned seg_start;
    bit              walking;

    size_report_t    expected_sizes[$];
    logic [7:0]      file_bytes[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int bytes_sent     = 0;
    int files_sent     = 0;

    function automatic bit sof_marker(input logic [7:0] m);
        return m[7:4] == SOF_NIBBLE &&
               (m[3:0] <= 4'h3 || (m[3:0] >= 4'h9 && m[3:0] <= 4'hB));
    endfunction

    task automatic clear_tracker();
        foreach (hdr_copy[i]) hdr_copy[i] = '0;
        foreach (win_copy[i]) win_copy[i] = '0;
        foreach (seg_copy[i]) seg_copy[i] = '0;
        byte_count = 0;
        seg_start  = 2;
        walking    = 1'b1;
    endtask

    // Apply one accepted byte; on the last byte of a file, queue the report
    // the block owes and start over for the next file.
    task automatic track_byte(input logic [7:0] b, input logic is_last);
        size_report_t    rep;
        longint unsigned idx;
        longint unsigned nxt;
        bit              jfif;
        idx = byte_count;
        for (int i = 0; i < WIN_LEN - 1; i++)
            win_copy[i] = win_copy[i + 1];
        win_copy[WIN_LEN - 1] = b;

        // A byte taken at the saturated position is not tracked at all.
        if (idx < POS_LIMIT) begin
            if (idx < HDR_LEN)
                hdr_copy[idx] = b;
            if (walking && idx == seg_start + WIN_LEN - 1) begin
                // The window now holds the whole awaited segment head.
                seg_copy[0] = win_copy[0];
                seg_copy[1] = win_copy[1];
                seg_copy[2] = win_copy[5];
                seg_copy[3] = win_copy[6];
                seg_copy[4] = win_copy[7];
                seg_copy[5] = win_copy[8];
                jfif = hdr_copy[0] == JPG_LEAD && hdr_copy[1] == JPG_SOI &&
                       hdr_copy[2] == JPG_LEAD && hdr_copy[3] == JPG_APP0 &&
                       hdr_copy[6] == CH_J && hdr_copy[7] == CH_F &&
                       hdr_copy[8] == CH_I && hdr_copy[9] == CH_F;
                // The first window is committed even for a non-JFIF file, but
                // the walk goes no further.
                if (seg_start == 2 && !jfif)
                    walking = 1'b0;
                else if (win_copy[0] != JPG_LEAD || sof_marker(win_copy[1]))
                    walking = 1'b0;
                else begin
                    nxt = seg_start + 2 + {win_copy[2], win_copy[3]};
                    seg_start = (nxt > POS_LIMIT) ? POS_LIMIT : nxt;
                end
            end
            byte_count = idx + 1;
        end

        if (is_last) begin
            rep = '0;
            if (byte_count >= HDR_LEN) begin
                if (hdr_copy[0] == JPG_LEAD && hdr_copy[1] == JPG_SOI &&
                    seg_copy[0] == JPG_LEAD) begin
                    rep.fmt    = FMT_JPEG;
                    rep.height = {16'd0, seg_copy[2], seg_copy[3]};
                    rep.width  = {16'd0, seg_copy[4], seg_copy[5]};
                end else if (hdr_copy[0] == CH_G && hdr_copy[1] == CH_I &&
                             hdr_copy[2] == CH_F) begin
                    rep.fmt    = FMT_GIF;
                    rep.width  = {16'd0, hdr_copy[7], hdr_copy[6]};
                    rep.height = {16'd0, hdr_copy[9], hdr_copy[8]};
                end else if (hdr_copy[0] == PNG_HIGH && hdr_copy[1] == CH_P &&
                             hdr_copy[2] == CH_N && hdr_copy[3] == CH_G &&
                             hdr_copy[4] == PNG_CR && hdr_copy[5] == PNG_LF &&
                             hdr_copy[6] == PNG_EOF && hdr_copy[7] == PNG_LF &&
                             hdr_copy[12] == CH_I && hdr_copy[13] == CH_H &&
                             hdr_copy[14] == CH_D && hdr_copy[15] == CH_R) begin
                    rep.fmt    = FMT_PNG;
                    rep.width  = {hdr_copy[16], hdr_copy[17], hdr_copy[18], hdr_copy[19]};
                    rep.height = {hdr_copy[20], hdr_copy[21], hdr_copy[22], hdr_copy[23]};
                end
            end
            rep.found = (rep.fmt != FMT_NONE);
            expected_sizes.push_back(rep);
            clear_tracker();
        end
    endtask

    // Compare one accepted report with the oldest pending one.
    task automatic check_report();
        size_report_t want;
        size_report_t got;
        got.found  = report_if.found;
        got.fmt    = report_if.image_format;
        got.width  = report_if.width;
        got.height = report_if.height;
        if (expected_sizes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MAX)
                $display("%0t ERROR: report with no file pending: %s%0d fmt=%0d w=%0h h=%0h",
                         $realtime, "found=", got.found, got.fmt, got.width, got.height);
        end else begin
            want = expected_sizes.pop_front();
            if (got.found !== want.found || got.fmt !== want.fmt ||
                got.width !== want.width || got.height !== want.height) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MAX)
                    $display({"%0t ERROR: expected found=%0d fmt=%0d w=%0h h=%0h,",
                              " got found=%0d fmt=%0d w=%0h h=%0h"},
                             $realtime, want.found, want.fmt, want.width, want.height,
                             got.found, got.fmt, got.width, got.height);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor and watchdog. Both channels are sampled at the rising edge; the
    // watchdog counts edges at which neither channel moves an item.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (rst_n) begin
            if (report_if.valid && report_if.ready) begin
                check_report();
                moved = 1'b1;
            end
            if (stream_if.valid && stream_if.ready) begin
                track_byte(stream_if.data_byte, stream_if.last_byte);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog: no item accepted for %0d cycles", $realtime, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // The result side stalls at random; the rate follows the current phase.
    always @(negedge clk)
        report_if.ready = rst_n && ($urandom_range(99) >= sink_idle_pct);

    // ------------------------------------------------------------------------
    // Sending. Inputs change only at the falling edge; valid is left high when
    // the next item follows at once, so it is written once per edge at most.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            stream_if.valid = 1'b0;
            @(negedge clk);
        end
        stream_if.valid     = 1'b1;
        stream_if.data_byte = b;
        stream_if.last_byte = is_last;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // ------------------------------------------------------------------------
    // File builders. Each one fills file_bytes with one whole file.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_dim(input logic [31:0] mask);
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return mask;
        return $urandom & mask;
    endfunction

    function automatic logic [7:0] pick_sof();
        int unsigned k;
        k = $urandom_range(6);
        return 8'(SOF_BASE + ((k < 4) ? k : k + 5));
    endfunction

    task automatic pad_random(input int upto);
        while (file_bytes.size() < upto)
            file_bytes.push_back(8'($urandom));
    endtask

    // JFIF file: APP0, some ordinary segments, then a SOF segment of which
    // only the first sof_keep bytes are kept, then tail random bytes.
    task automatic build_jpeg(input logic [15:0] app_len, input int n_segs,
                              input logic [7:0] sof, input logic [15:0] h,
                              input logic [15:0] w, input int sof_keep, input int tail);
        logic [7:0]  sof_seg[12];
        logic [7:0]  mk;
        logic [15:0] seg_len;
        file_bytes = {JPG_LEAD, JPG_SOI, JPG_LEAD, JPG_APP0, app_len[15:8], app_len[7:0],
                      CH_J, CH_F, CH_I, CH_F, 8'h00};
        // A huge APP0 length is only padded a little: the walk never gets past it.
        while (file_bytes.size() < 4 + app_len && file_bytes.size() < 40)
            file_bytes.push_back(8'($urandom));
        repeat (n_segs) begin
            mk = 8'($urandom);
            if (sof_marker(mk))
                mk = mk ^ NOT_SOF_BIT;
            seg_len = 16'($urandom_range(2, 14));
            file_bytes.push_back(JPG_LEAD);
            file_bytes.push_back(mk);
            file_bytes.push_back(seg_len[15:8]);
            file_bytes.push_back(seg_len[7:0]);
            pad_random(file_bytes.size() + seg_len - 2);
        end
        sof_seg = '{JPG_LEAD, sof, 8'h00, 8'h11, 8'h08, h[15:8], h[7:0],
                    w[15:8], w[7:0], 8'h03, 8'h01, 8'h22};
        for (int i = 0; i < sof_keep; i++)
            file_bytes.push_back(sof_seg[i]);
        pad_random(file_bytes.size() + tail);
    endtask

    task automatic build_gif(input logic [15:0] w, input logic [15:0] h, input int len);
        file_bytes = {CH_G, CH_I, CH_F, 8'h38, 8'h39, 8'h61, w[7:0], w[15:8], h[7:0], h[15:8]};
        pad_random(len);
    endtask

    task automatic build_png(input logic [31:0] w, input logic [31:0] h, input int tail);
        file_bytes = {PNG_HIGH, CH_P, CH_N, CH_G, PNG_CR, PNG_LF, PNG_EOF, PNG_LF,
                      8'h00, 8'h00, 8'h00, 8'h0D, CH_I, CH_H, CH_D, CH_R,
                      w[31:24], w[23:16], w[15:8], w[7:0],
                      h[31:24], h[23:16], h[15:8], h[7:0]};
        pad_random(24 + tail);
    endtask

    // Three bytes of JPEG signature and nothing more: the size comes from the
    // first window, bytes 7 to 10.
    task automatic build_plain_jpeg(input int len);
        file_bytes = {JPG_LEAD, JPG_SOI, JPG_LEAD};
        pad_random(len);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // GIF and PNG headers with their fields at the extremes.
    task automatic test_gif_png_headers();
        build_gif(16'hFFFF, 16'h0000, 24);
        send_file();
        build_gif(16'h0001, 16'h8000, 30);
        send_file();
        build_png(32'hFFFF_FFFF, 32'h0000_0001, 0);
        send_file();
        build_png(32'h8000_0000, 32'hFFFF_FFFF, 4);
        send_file();
    endtask

    // The JPEG segment walk: SOF stop, cut-off window, huge segment length,
    // a lead byte that is not 0xFF, and a JPEG without the JFIF tag.
    task automatic test_jpeg_segment_walk();
        build_jpeg(16'd16, 1, SOF_BASE, 16'h1234, 16'hABCD, 12, 0);
        send_file();
        build_jpeg(16'd16, 0, pick_sof(), 16'hFFFF, 16'h0000, 12, 3);
        send_file();
        // The SOF window is cut short, so the segment before it stays committed.
        build_jpeg(16'd16, 1, pick_sof(), 16'h0101, 16'h0202, 7, 0);
        send_file();
        // APP0 claims 0xFFFF bytes: only the APP0 window is ever committed.
        build_jpeg(16'hFFFF, 0, pick_sof(), 16'h0303, 16'h0404, 12, 0);
        send_file();
        // The segment after APP0 starts with 0x00: the walk stops on it and
        // the committed lead byte is no longer 0xFF, so nothing is found.
        build_jpeg(16'd16, 1, pick_sof(), 16'h0505, 16'h0606, 12, 0);
        file_bytes[20] = 8'h00;
        send_file();
        build_plain_jpeg(24);
        send_file();
    endtask

    // Files too short to judge, and files with no known signature.
    task automatic test_short_and_unknown();
        build_png(32'd640, 32'd480, 0);
        void'(file_bytes.pop_back());
        send_file();
        file_bytes = {JPG_LEAD};
        send_file();
        file_bytes = {};
        repeat (24) file_bytes.push_back(8'h00);
        send_file();
    endtask

    // Mostly well-formed files with random content, the rest noise, cut
    // files and files with one corrupted byte.
    task automatic test_random_files(input int n_bytes, input int n_files);
        int start_bytes;
        int start_files;
        int unsigned sel;
        int idx;
        start_bytes = bytes_sent;
        start_files = files_sent;
        while (bytes_sent - start_bytes < n_bytes || files_sent - start_files < n_files) begin
            sel = $urandom_range(99);
            if (sel < 35)
                build_jpeg(($urandom_range(3) == 0) ? 16'($urandom_range(7, 20)) : 16'd16,
                           $urandom_range(3), pick_sof(), 16'(pick_dim(32'hFFFF)),
                           16'(pick_dim(32'hFFFF)),
                           ($urandom_range(4) == 0) ? $urandom_range(1, 11) : 12,
                           $urandom_range(6));
            else if (sel < 47)
                build_plain_jpeg($urandom_range(12, 33));
            else if (sel < 65)
                build_gif(16'(pick_dim(32'hFFFF)), 16'(pick_dim(32'hFFFF)),
                          $urandom_range(20, 36));
            else if (sel < 83)
                build_png(pick_dim(32'hFFFF_FFFF), pick_dim(32'hFFFF_FFFF), $urandom_range(8));
            else begin
                file_bytes = {};
                pad_random($urandom_range(1, 40));
            end

            // Broken files: one corrupted byte in the header area, or cut short.
            if ($urandom_range(99) < 15) begin
                idx = $urandom_range(file_bytes.size() - 1);
                if (idx > 23)
                    idx = $urandom_range(23);
                if (idx < file_bytes.size())
                    file_bytes[idx] = 8'($urandom);
            end
            if ($urandom_range(99) < 8 && file_bytes.size() > 1)
                file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 2)];
            send_file();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        stream_if.valid     = 1'b0;
        stream_if.data_byte = 8'h00;
        stream_if.last_byte = 1'b0;
        report_if.ready     = 1'b0;
        clear_tracker();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles a little, receiver stalls a lot.
        src_idle_pct  = 15;
        sink_idle_pct = 73;
        test_gif_png_headers();
        test_jpeg_segment_walk();
        test_short_and_unknown();
        test_random_files(150, 5);

        // The other way round.
        src_idle_pct  = 73;
        sink_idle_pct = 15;
        test_random_files(150, 5);

        // Both sides at full rate.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_files(150, 5);

        @(negedge clk);
        stream_if.valid = 1'b0;

        // Drain the reports still in flight, then run on so that the block can
        // show any stray one.
        while (expected_sizes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/ihs_pkg.sv
rtl/ihs_if.sv
rtl/ihs_front.sv
rtl/ihs_queue.sv
rtl/ihs_back.sv
rtl/image_header_size_sniffer.sv
dv/tb.sv
